// ===== rtl/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg - shared definitions for the Mandelbrot escape-time pixel engine
// Register map codes, reset values, queue sizing and the queue status word.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int COUNT_W = 16;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_ROWS    = 2'd0;
  localparam logic [1:0] REG_COLUMNS = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  localparam int ROWS_RESET    = 24;
  localparam int COLUMNS_RESET = 80;
  localparam int LIMIT_RESET   = 256;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic empty;
    logic full;
  } mep_qstat_t;

endpackage

// ===== rtl/mandelbrot_escape_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel - escape-time test for one pixel of an image
// Maps a pixel to the point c and counts Mandelbrot iterations until escape.
// ----------------------------------------------------------------------------
// Usage: a pixel word (row, column) enters on the in_ channel and one result
// word (in_set, escape_count) leaves on the out_ channel, in order. A word
// moves when valid is high and stall is low. Image size and iteration limit
// sit in three APB registers at 0x0, 0x4 and 0x8; write them only while no
// pixel is in flight.
// Flow: the front end maps a pixel at one restoring-divider bit per cycle,
// then hands it over in a separate step, keeping in_stall high until the
// point has passed into a two-entry queue. The back end runs each radius
// test as a magnitude step, the four partial product steps of its shared
// multipliers, a test step and, unless the point is finished, an update
// step. A point that escapes needs escape_count + 1 tests, one that reaches
// the limit escape_count tests.
// Reset clears the state machines, queue pointers and out_valid and loads
// 24 rows, 80 columns and a limit of 256. A stalled result word is held in
// the output register; the back end waits in its finish step, and once the
// queue is full the front end holds its mapped pixel with in_stall high.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel #(
  parameter int FRAC_BITS = 28,
  parameter int DIM_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [DIM_BITS-1:0]           in_pixel_row,
  input  logic [DIM_BITS-1:0]           in_pixel_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_in_set,
  output logic [mep_pkg::COUNT_W-1:0]   out_escape_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mep_pkg::ADDR_W-1:0]    paddr,
  input  logic [mep_pkg::DATA_W-1:0]    pwdata,
  output logic [mep_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int W   = FRAC_BITS + 4;
  localparam int DMW = DIM_BITS + 1;
  localparam int DTW = mep_pkg::DATA_W;
  localparam int CNW = mep_pkg::COUNT_W;

  logic [DMW-1:0]        rows_r, columns_r;
  logic [CNW-1:0]        limit_r;
  logic [1:0]            reg_sel;
  logic                  reg_write;
  mep_pkg::mep_qstat_t   q_stat;
  logic                  q_push, q_pop;
  logic [2*W-1:0]        q_push_data, q_pop_data;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[mep_pkg::ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= DMW'(mep_pkg::ROWS_RESET);
      columns_r <= DMW'(mep_pkg::COLUMNS_RESET);
      limit_r   <= CNW'(mep_pkg::LIMIT_RESET);
    end else if (reg_write) begin
      case (reg_sel)
        mep_pkg::REG_ROWS:    rows_r    <= pwdata[DMW-1:0];
        mep_pkg::REG_COLUMNS: columns_r <= pwdata[DMW-1:0];
        mep_pkg::REG_LIMIT:   limit_r   <= pwdata[CNW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mep_pkg::REG_ROWS:    prdata = DTW'(rows_r);
      mep_pkg::REG_COLUMNS: prdata = DTW'(columns_r);
      mep_pkg::REG_LIMIT:   prdata = DTW'(limit_r);
      default:              prdata = '0;
    endcase
  end

  mep_front #(
    .FRAC_BITS (FRAC_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_column (in_pixel_column),
    .image_rows      (rows_r),
    .image_columns   (columns_r),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_data          (q_push_data)
  );

  mep_queue #(
    .DW (2*W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  mep_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .q_data           (q_pop_data),
    .iteration_limit  (limit_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_in_set       (out_in_set),
    .out_escape_count (out_escape_count)
  );

endmodule

// ===== rtl/mep_queue.sv =====
// ----------------------------------------------------------------------------
// mep_queue - short queue of prepared points between front and back end
// Holds the saturated real and imaginary parts of c for pending pixels.
// ----------------------------------------------------------------------------
module mep_queue #(
  parameter int DW = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DW-1:0]       push_data,
  input  logic                pop,
  output logic [DW-1:0]       pop_data,
  output mep_pkg::mep_qstat_t stat
);

  logic [DW-1:0]                   entry_r [mep_pkg::Q_DEPTH];
  logic [mep_pkg::Q_PTR_W-1:0]     wptr_r, wptr_nxt;
  logic [mep_pkg::Q_PTR_W-1:0]     rptr_r, rptr_nxt;
  logic [mep_pkg::Q_CNT_W-1:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  localparam logic [mep_pkg::Q_PTR_W-1:0] LAST_PTR =
    mep_pkg::Q_PTR_W'(mep_pkg::Q_DEPTH - 1);
  localparam logic [mep_pkg::Q_CNT_W-1:0] FULL_CNT =
    mep_pkg::Q_CNT_W'(mep_pkg::Q_DEPTH);

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entry_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue fill count beyond depth");
`endif

endmodule

// ===== rtl/mep_front.sv =====
// ----------------------------------------------------------------------------
// mep_front - pixel intake and coordinate mapping
// Accepts a pixel word and maps row and column to the point c by two
// restoring dividers running side by side, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mep_front #(
  parameter int FRAC_BITS = 28,
  parameter int DIM_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [DIM_BITS-1:0]           in_pixel_row,
  input  logic [DIM_BITS-1:0]           in_pixel_column,
  input  logic [DIM_BITS:0]             image_rows,
  input  logic [DIM_BITS:0]             image_columns,
  input  mep_pkg::mep_qstat_t           q_stat,
  output logic                          q_push,
  output logic [2*(FRAC_BITS+4)-1:0]    q_data
);

  localparam int W  = FRAC_BITS + 4;
  localparam int DW = DIM_BITS + 1;
  localparam int NB = DIM_BITS + 1 + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);

  // 1.5 and 1.0 in the quotient's scale, and the largest Q4 value
  localparam logic [NB:0] OFF_RE = {{(NB-FRAC_BITS){1'b0}}, 2'b11, {(FRAC_BITS-1){1'b0}}};
  localparam logic [NB:0] OFF_IM = {{(NB-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [NB:0] QMAX   = {{(NB+2-W){1'b0}}, {(W-1){1'b1}}};

  typedef enum logic [2:0] {
    FE_IDLE = 3'b001,
    FE_DIV  = 3'b010,
    FE_PUSH = 3'b100
  } fe_state_t;

  fe_state_t         state_r, state_nxt;
  logic [NB-1:0]     quo_r   [2];
  logic [NB-1:0]     quo_nxt [2];
  logic [DW-1:0]     rem_r   [2];
  logic [DW-1:0]     rem_nxt [2];
  logic [DW-1:0]     div_r   [2];
  logic [DW:0]       trial   [2];
  logic [DW:0]       diff    [2];
  logic signed [NB:0] shifted [2];
  logic [W-1:0]      coord   [2];
  logic [CW-1:0]     count_r;
  logic              accept;

  assign in_stall = (state_r != FE_IDLE);
  assign accept   = in_valid && (state_r == FE_IDLE);
  assign q_push   = (state_r == FE_PUSH) && !q_stat.full;
  assign q_data   = {coord[0], coord[1]};

  // Lane 0 carries the column (real part), lane 1 the row (imaginary part).
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem_r[i], quo_r[i][NB-1]};
      diff[i]  = trial[i] - {1'b0, div_r[i]};
      if (trial[i] >= {1'b0, div_r[i]}) begin
        rem_nxt[i] = diff[i][DW-1:0];
        quo_nxt[i] = {quo_r[i][NB-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][DW-1:0];
        quo_nxt[i] = {quo_r[i][NB-2:0], 1'b0};
      end
    end
  end

  // The quotient is never negative and the offsets are at most 1.5, so only
  // the upper bound of the Q4 range can be exceeded.
  always_comb begin
    shifted[0] = $signed({1'b0, quo_r[0]} - OFF_RE);
    shifted[1] = $signed({1'b0, quo_r[1]} - OFF_IM);
    for (int i = 0; i < 2; i++) begin
      if (shifted[i] > $signed(QMAX)) begin
        coord[i] = QMAX[W-1:0];
      end else begin
        coord[i] = shifted[i][W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: begin
        if (accept) begin
          state_nxt = FE_DIV;
        end
      end
      FE_DIV: begin
        if (count_r == CW'(1)) begin
          state_nxt = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      quo_r[0] <= NB'({in_pixel_column, 1'b0}) << FRAC_BITS;
      quo_r[1] <= NB'({in_pixel_row, 1'b0}) << FRAC_BITS;
      rem_r[0] <= '0;
      rem_r[1] <= '0;
      div_r[0] <= (image_columns == '0) ? DW'(1) : image_columns;
      div_r[1] <= (image_rows == '0) ? DW'(1) : image_rows;
      count_r  <= CW'(NB);
    end else if (state_r == FE_DIV) begin
      quo_r[0] <= quo_nxt[0];
      quo_r[1] <= quo_nxt[1];
      rem_r[0] <= rem_nxt[0];
      rem_r[1] <= rem_nxt[1];
      count_r  <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/mep_back.sv =====
// ----------------------------------------------------------------------------
// mep_back - escape-time iteration engine
// Iterates z = z*z + c on one point at a time. The three products are built
// by accumulating half-width partial products, then the radius test,
// counter check and update follow.
// ----------------------------------------------------------------------------
module mep_back #(
  parameter int FRAC_BITS = 28
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mep_pkg::mep_qstat_t                q_stat,
  output logic                               q_pop,
  input  logic [2*(FRAC_BITS+4)-1:0]         q_data,
  input  logic [mep_pkg::COUNT_W-1:0]        iteration_limit,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_in_set,
  output logic [mep_pkg::COUNT_W-1:0]        out_escape_count
);

  localparam int W   = FRAC_BITS + 4;
  localparam int H   = (W + 1) / 2;
  localparam int HW2 = 2 * H;
  localparam int PW  = 4 * H;
  localparam int RW  = PW + 2;
  localparam int SHW = $clog2(PW);

  localparam logic [PW:0] RAD =
    {{(PW-2*FRAC_BITS-2){1'b0}}, 1'b1, {(2*FRAC_BITS+2){1'b0}}};
  localparam logic signed [RW-1:0] QMAX_R = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] QMIN_R = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef enum logic [5:0] {
    BE_IDLE = 6'b000001,
    BE_MAG  = 6'b000010,
    BE_MUL  = 6'b000100,
    BE_CHK  = 6'b001000,
    BE_UPD  = 6'b010000,
    BE_DONE = 6'b100000
  } be_state_t;

  be_state_t                   state_r, state_nxt;
  logic signed [W-1:0]         cr_r, ci_r, x_r, y_r;
  logic [HW2-1:0]              mx_r, my_r;
  logic                        neg_r;
  logic [PW-1:0]               acc_xx_r, acc_yy_r, acc_xy_r;
  logic [1:0]                  k_r;
  logic signed [RW-1:0]        re_r, im_r;
  logic [mep_pkg::COUNT_W-1:0] n_r, n_inc;
  logic                        out_valid_r, out_in_set_r;
  logic [mep_pkg::COUNT_W-1:0] out_count_r;

  logic [H-1:0]                xa, xb, ya, yb;
  logic [HW2-1:0]              pxx, pyy, pxy;
  logic [SHW-1:0]              sh;
  logic [PW:0]                 rad_sum;
  logic                        in_radius, below_limit, finish, out_free;
  logic [W-1:0]                ux, uy;
  logic signed [RW-1:0]        re_diff, im_mag, im_sgn;
  logic signed [RW-1:0]        im_dbl, re_sum, im_sum;

  function automatic logic signed [W-1:0] sat_q(input logic signed [RW-1:0] v);
    logic signed [W-1:0] r;
    if (v > QMAX_R) begin
      r = QMAX_R[W-1:0];
    end else if (v < QMIN_R) begin
      r = QMIN_R[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  assign out_valid        = out_valid_r;
  assign out_in_set       = out_in_set_r;
  assign out_escape_count = out_count_r;
  assign out_free         = !out_valid_r || !out_stall;
  assign q_pop            = (state_r == BE_IDLE) && !q_stat.empty;

  // Magnitudes of the current z, taken apart into halves for the multipliers
  assign ux = x_r[W-1] ? (~$unsigned(x_r) + 1'b1) : $unsigned(x_r);
  assign uy = y_r[W-1] ? (~$unsigned(y_r) + 1'b1) : $unsigned(y_r);

  assign xa  = k_r[1] ? mx_r[HW2-1:H] : mx_r[H-1:0];
  assign xb  = k_r[0] ? mx_r[HW2-1:H] : mx_r[H-1:0];
  assign ya  = k_r[1] ? my_r[HW2-1:H] : my_r[H-1:0];
  assign yb  = k_r[0] ? my_r[HW2-1:H] : my_r[H-1:0];
  assign pxx = HW2'(xa) * HW2'(xb);
  assign pyy = HW2'(ya) * HW2'(yb);
  assign pxy = HW2'(xa) * HW2'(yb);

  always_comb begin
    case (k_r)
      2'd0:    sh = '0;
      2'd3:    sh = SHW'(HW2);
      default: sh = SHW'(H);
    endcase
  end

  // Radius test and counter check on the finished products
  assign rad_sum     = {1'b0, acc_xx_r} + {1'b0, acc_yy_r};
  assign in_radius   = (rad_sum < RAD);
  assign n_inc       = n_r + 1'b1;
  assign below_limit = (n_inc < iteration_limit);
  assign finish      = !in_radius || !below_limit;
  assign re_diff     = $signed(RW'(acc_xx_r) - RW'(acc_yy_r));
  assign im_mag      = $signed(RW'(acc_xy_r));
  assign im_sgn      = neg_r ? -im_mag : im_mag;

  // Rounding toward minus infinity is the arithmetic shift itself.
  assign im_dbl = {im_r[RW-2:0], 1'b0};
  assign re_sum = (re_r >>> FRAC_BITS) + RW'(cr_r);
  assign im_sum = (im_dbl >>> FRAC_BITS) + RW'(ci_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = BE_MAG;
        end
      end
      BE_MAG:  state_nxt = BE_MUL;
      BE_MUL: begin
        if (k_r == 2'd3) begin
          state_nxt = BE_CHK;
        end
      end
      BE_CHK:  state_nxt = finish ? BE_DONE : BE_UPD;
      BE_UPD:  state_nxt = BE_MAG;
      BE_DONE: begin
        if (out_free) begin
          state_nxt = BE_IDLE;
        end
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BE_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BE_IDLE: begin
        cr_r <= $signed(q_data[2*W-1:W]);
        ci_r <= $signed(q_data[W-1:0]);
        x_r  <= '0;
        y_r  <= '0;
        n_r  <= '0;
      end
      BE_MAG: begin
        mx_r     <= HW2'(ux);
        my_r     <= HW2'(uy);
        neg_r    <= x_r[W-1] ^ y_r[W-1];
        acc_xx_r <= '0;
        acc_yy_r <= '0;
        acc_xy_r <= '0;
        k_r      <= '0;
      end
      BE_MUL: begin
        acc_xx_r <= acc_xx_r + (PW'(pxx) << sh);
        acc_yy_r <= acc_yy_r + (PW'(pyy) << sh);
        acc_xy_r <= acc_xy_r + (PW'(pxy) << sh);
        k_r      <= k_r + 1'b1;
      end
      BE_CHK: begin
        if (in_radius) begin
          n_r <= n_inc;
        end
        re_r <= re_diff;
        im_r <= im_sgn;
      end
      BE_UPD: begin
        x_r <= sat_q(re_sum);
        y_r <= sat_q(im_sum);
      end
      BE_DONE: begin
        if (out_free) begin
          out_in_set_r <= (n_r == iteration_limit);
          out_count_r  <= n_r;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  a_mul_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_MUL && k_r == 2'd3) |=> (state_r == BE_CHK))
    else $error("partial product sequence did not end after four steps");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_MAG) |=> (acc_xx_r == '0 && acc_yy_r == '0 && acc_xy_r == '0))
    else $error("accumulators not cleared before products");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_DONE) |-> (n_r != '0))
    else $error("finished point with a zero count");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == BE_DONE))
    else $error("result word raised outside the finish step");
`endif

endmodule

// ===== test/escape_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_monitor - result checker for the Mandelbrot escape-time pixel engine
// Follows the register writes on the APB port. It predicts the escape count
// of every pixel word when that word is accepted, and compares each result
// word, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module escape_monitor #(
  parameter int FRAC_BITS = 28,
  parameter int DIM_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [DIM_BITS-1:0]           in_pixel_row,
  input  logic [DIM_BITS-1:0]           in_pixel_column,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_in_set,
  input  logic [mep_pkg::COUNT_W-1:0]   out_escape_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [mep_pkg::ADDR_W-1:0]    paddr,
  input  logic [mep_pkg::DATA_W-1:0]    pwdata,
  output int                            fail_count,
  output int                            pending
);

  // Q4.F limits and the constants of the pixel mapping
  localparam longint Q_MAX   = (64'sd8 <<< FRAC_BITS) - 64'sd1;
  localparam longint Q_MIN   = -Q_MAX - 64'sd1;
  localparam longint Q_ONE   = 64'sd1 <<< FRAC_BITS;

  typedef struct {
    logic [DIM_BITS-1:0]          row;
    logic [DIM_BITS-1:0]          column;
    logic                         in_set;
    logic [mep_pkg::COUNT_W-1:0]  count;
  } escape_t;

  escape_t escape_queue[$];

  logic [DIM_BITS:0]           cur_rows;
  logic [DIM_BITS:0]           cur_columns;
  logic [mep_pkg::COUNT_W-1:0] cur_limit;

  function automatic longint clamp_q(input logic signed [127:0] v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return longint'(v);
  endfunction

  // floor(2 * idx * 2^F / dim) - offset, where a dimension of zero counts as one.
  function automatic longint pixel_coord(input logic [DIM_BITS-1:0] idx,
                                         input logic [DIM_BITS:0] dim,
                                         input longint offset);
    longint unsigned num;
    longint unsigned den;
    logic signed [127:0] v;
    num = 64'(idx) << (FRAC_BITS + 1);
    den = (dim == 0) ? 64'd1 : 64'(dim);
    v = $signed({64'd0, num / den}) - offset;
    return clamp_q(v);
  endfunction

  function automatic escape_t escape_time(input logic [DIM_BITS-1:0] row,
                                          input logic [DIM_BITS-1:0] column);
    escape_t r;
    longint cr;
    longint ci;
    logic signed [127:0] x;
    logic signed [127:0] y;
    logic signed [127:0] re;
    logic signed [127:0] im;
    int unsigned n;
    cr = pixel_coord(column, cur_columns, Q_ONE + Q_ONE / 2);
    ci = pixel_coord(row, cur_rows, Q_ONE);
    x = 0;
    y = 0;
    n = 0;
    // The radius test works on the exact squares, before any shift.
    while (x * x + y * y < (128'sd1 <<< (2 * FRAC_BITS + 2))) begin
      n++;
      if (n >= cur_limit) break;
      re = ((x * x - y * y) >>> FRAC_BITS) + cr;
      im = ((2 * x * y) >>> FRAC_BITS) + ci;
      x = clamp_q(re);
      y = clamp_q(im);
    end
    r.row = row;
    r.column = column;
    r.in_set = (n == cur_limit);
    r.count = mep_pkg::COUNT_W'(n);
    return r;
  endfunction

  always @(posedge clk) begin
    escape_t want;
    if (!rst_n) begin
      escape_queue.delete();
      cur_rows = (DIM_BITS + 1)'(mep_pkg::ROWS_RESET);
      cur_columns = (DIM_BITS + 1)'(mep_pkg::COLUMNS_RESET);
      cur_limit = mep_pkg::COUNT_W'(mep_pkg::LIMIT_RESET);
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mep_pkg::REG_ROWS:    cur_rows = pwdata[DIM_BITS:0];
          mep_pkg::REG_COLUMNS: cur_columns = pwdata[DIM_BITS:0];
          mep_pkg::REG_LIMIT:   cur_limit = pwdata[mep_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (escape_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with none expected: in_set %0b count %0d",
                     $time, out_in_set, out_escape_count);
        end else begin
          want = escape_queue.pop_front();
          if (out_in_set !== want.in_set || out_escape_count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: pixel (%0d, %0d): expected %0b/%0d, got %0b/%0d",
                       $time, want.row, want.column, want.in_set, want.count,
                       out_in_set, out_escape_count);
          end
        end
      end
      if (in_valid && !in_stall)
        escape_queue.push_back(escape_time(in_pixel_row, in_pixel_column));
    end
    pending = escape_queue.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - top level for the Mandelbrot escape-time pixel engine
// Writes image sizes and iteration limits over APB, sends directed and random
// pixel words with random idle and stall bursts, and gives the verdict from
// the failure and pending counts of the escape monitor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAC_BITS = 28;
  localparam int DIM_BITS  = 12;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [DIM_BITS-1:0]           in_pixel_row;
  logic [DIM_BITS-1:0]           in_pixel_column;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_in_set;
  logic [mep_pkg::COUNT_W-1:0]   out_escape_count;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mep_pkg::ADDR_W-1:0]    paddr;
  logic [mep_pkg::DATA_W-1:0]    pwdata;
  logic [mep_pkg::DATA_W-1:0]    prdata;
  logic                          pready;

  int fail_count;
  int pending;
  bit gaps_on;
  int stall_left;
  logic [DIM_BITS:0] phase_rows;
  logic [DIM_BITS:0] phase_columns;

  always #5 clk = ~clk;

  mandelbrot_escape_pixel #(
    .FRAC_BITS (FRAC_BITS),
    .DIM_BITS  (DIM_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_column  (in_pixel_column),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_in_set       (out_in_set),
    .out_escape_count (out_escape_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  escape_monitor #(
    .FRAC_BITS (FRAC_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_column  (in_pixel_column),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_in_set       (out_in_set),
    .out_escape_count (out_escape_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Stall bursts on the result side; no new burst starts while gaps_on is low.
  always @(negedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic apb_write(input logic [1:0] reg_idx,
                           input logic [mep_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Upper bits beyond each register's width are sometimes filled with junk.
  task automatic configure(input logic [DIM_BITS:0] rows,
                           input logic [DIM_BITS:0] columns,
                           input logic [mep_pkg::COUNT_W-1:0] limit,
                           input bit junk);
    logic [mep_pkg::DATA_W-1:0] noise;
    noise = junk ? $urandom : '0;
    apb_write(mep_pkg::REG_ROWS,
              (noise & 32'hFFFF_E000) | mep_pkg::DATA_W'(rows));
    apb_write(mep_pkg::REG_COLUMNS,
              (noise & 32'hFFFF_E000) | mep_pkg::DATA_W'(columns));
    apb_write(mep_pkg::REG_LIMIT,
              (noise & 32'hFFFF_0000) | mep_pkg::DATA_W'(limit));
    phase_rows = rows;
    phase_columns = columns;
  endtask

  task automatic send_pixel(input logic [DIM_BITS-1:0] row,
                            input logic [DIM_BITS-1:0] column);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_pixel_row = row;
    in_pixel_column = column;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Lowers valid and waits until every expected result word has arrived.
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [DIM_BITS:0] random_dim();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: return (DIM_BITS + 1)'($urandom_range(1, 32));
      6, 7, 8, 9:       return (DIM_BITS + 1)'($urandom_range(33, 300));
      10, 11, 12:       return (DIM_BITS + 1)'($urandom_range(301, 4096));
      13:               return (DIM_BITS + 1)'($urandom_range(4097, 8191));
      14:               return '0;
      default:          return (DIM_BITS + 1)'(4096);
    endcase
  endfunction

  // Mostly an index inside the image; now and then any 12-bit value.
  function automatic logic [DIM_BITS-1:0] random_index(input logic [DIM_BITS:0] dim);
    int unsigned span;
    span = (dim == 0) ? 1 : ((dim > 4096) ? 4096 : dim);
    if ($urandom_range(0, 9) == 0) return DIM_BITS'($urandom);
    return DIM_BITS'($urandom_range(0, span - 1));
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_row = '0;
    in_pixel_column = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    phase_rows = (DIM_BITS + 1)'(mep_pkg::ROWS_RESET);
    phase_columns = (DIM_BITS + 1)'(mep_pkg::COLUMNS_RESET);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: corners, the centre point c = 0 and indices past the image.
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(12, 60);
    send_pixel(23, 79);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    drain();

    // A limit of zero and a limit of one both stop the counter at one.
    configure(24, 80, 0, 1'b0);
    send_pixel(12, 60);
    send_pixel(0, 0);
    drain();
    configure(24, 80, 1, 1'b0);
    send_pixel(12, 60);
    send_pixel(0, 0);
    drain();

    // Zero dimensions act as one; large indices drive c into saturation.
    configure(0, 0, 16, 1'b0);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(4095, 4095);
    drain();
    configure(1, 1, 4, 1'b0);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(4095, 4095);
    drain();

    // Widest dimension register and the largest limit, with one point inside.
    configure(8191, 4096, 65535, 1'b0);
    send_pixel(4095, 3072);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      gaps_on = (phase != 2) && (phase != 5);
      configure(random_dim(), random_dim(),
                (phase == 0) ? mep_pkg::COUNT_W'(mep_pkg::LIMIT_RESET)
                             : mep_pkg::COUNT_W'($urandom_range(2, 48)),
                1'($urandom_range(0, 1)));
      repeat (325) send_pixel(random_index(phase_rows), random_index(phase_columns));
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #300_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mep_pkg.sv
rtl/mep_queue.sv
rtl/mep_front.sv
rtl/mep_back.sv
rtl/mandelbrot_escape_pixel.sv
test/escape_monitor.sv
test/testbench.sv
